/* sv/twc_pkg.sv */
package twc_pkg;

   // Window length default and sequencer sizing.
   localparam int unsigned SAMPLES_DEFAULT = 16;
   localparam int unsigned PC_W            = 4;
   localparam int unsigned CSR_ADDR_W      = 4;
   localparam int unsigned CSR_DATA_W      = 32;

   // Shared multiplier operand and product widths.
   localparam int unsigned MUL_A_W = 32;
   localparam int unsigned MUL_B_W = 24;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

   // Field widths.
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SCALE_W  = 24;
   localparam int unsigned VOLT_W   = 19;
   localparam int unsigned TURB_W   = 16;
   localparam int unsigned Y_W      = 20;

   // Reset values of the registers.
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd216270;
   localparam logic [VOLT_W-1:0]  OPEN_RESET   = 19'd19661;
   localparam logic [TURB_W-1:0]  REJECT_RESET = 16'd16000;

   // Register indexes on the control port.
   localparam logic [1:0] REG_VOLT_SCALE   = 2'd0;
   localparam logic [1:0] REG_CALIBRATED   = 2'd1;
   localparam logic [1:0] REG_OPEN_THRESH  = 2'd2;
   localparam logic [1:0] REG_REJECT_LIMIT = 2'd3;

   // Average: floor(sum / SAMPLES) as (sum * ceil(2^28 / SAMPLES)) >> 28.
   localparam int unsigned AVG_SHIFT = 28;

   // Polynomial in 2^-16 V units, scaled so that N is ten times NTU times 2^32:
   //   N = V * (57423 * 2^16 - 11204 * V) - 43529 * 2^32
   localparam logic [13:0]       COEF_SQ     = 14'd11204;
   localparam logic [31:0]       COEF_LIN    = 32'd3763273728;
   localparam logic [PROD_W-1:0] POLY_OFFSET = 56'd186955631427584;
   localparam logic [PROD_W-1:0] ROUND_HALF  = 56'd1342177280;
   localparam int unsigned       TURB_SHIFT  = 28;

   // Division by ten of the 20-bit rounded value: (y * ceil(2^24 / 10)) >> 24.
   localparam logic [20:0]  RECIP_TEN = 21'd1677722;
   localparam int unsigned  TEN_SHIFT = 24;

   localparam logic [VOLT_W-1:0] VOLT_MAX = 19'd524287;
   localparam logic [VOLT_W-1:0] V_CLEAR  = 19'd163840;
   localparam logic [TURB_W-1:0] NTU_MAX  = 16'd48000;

   typedef enum logic [1:0] {
      FAULT_OK     = 2'd0,
      FAULT_OPEN   = 2'd1,
      FAULT_REJECT = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      MUL_NONE  = 3'd0,
      MUL_AVG   = 3'd1,
      MUL_VOLT  = 3'd2,
      MUL_QUAD  = 3'd3,
      MUL_POLY  = 3'd4,
      MUL_DIV10 = 3'd5
   } mul_op_type;

   typedef enum logic [2:0] {
      LD_NONE   = 3'd0,
      LD_AVG    = 3'd1,
      LD_VOLT   = 3'd2,
      LD_INNER  = 3'd3,
      LD_RAW    = 3'd4,
      LD_RESULT = 3'd5
   } load_type;

   typedef enum logic [1:0] {
      CND_NEVER       = 2'd0,
      CND_ALWAYS      = 2'd1,
      CND_NO_GO       = 2'd2,
      CND_OUT_BLOCKED = 2'd3
   } cond_type;

   typedef struct packed {
      mul_op_type       mul;
      load_type         load;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   // Step numbers of the program.
   localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [PC_W-1:0] STEP_MUL_AVG   = 4'd1;
   localparam logic [PC_W-1:0] STEP_LD_AVG    = 4'd2;
   localparam logic [PC_W-1:0] STEP_MUL_VOLT  = 4'd3;
   localparam logic [PC_W-1:0] STEP_LD_VOLT   = 4'd4;
   localparam logic [PC_W-1:0] STEP_MUL_QUAD  = 4'd5;
   localparam logic [PC_W-1:0] STEP_LD_INNER  = 4'd6;
   localparam logic [PC_W-1:0] STEP_MUL_POLY  = 4'd7;
   localparam logic [PC_W-1:0] STEP_LD_RAW    = 4'd8;
   localparam logic [PC_W-1:0] STEP_MUL_DIV10 = 4'd9;
   localparam logic [PC_W-1:0] STEP_RESULT    = 4'd10;
   localparam logic [PC_W-1:0] STEP_RETURN    = 4'd11;

   // Control store: a jump is taken to target when the condition holds,
   // otherwise the step counter advances by one.
   function automatic ctrl_word_type program_rom(logic [PC_W-1:0] step);
      ctrl_word_type w;
      w = '{mul: MUL_NONE, load: LD_NONE, cond: CND_NEVER, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:      w = '{MUL_NONE,  LD_NONE,   CND_NO_GO,       STEP_IDLE};
         STEP_MUL_AVG:   w = '{MUL_AVG,   LD_NONE,   CND_NEVER,       STEP_IDLE};
         STEP_LD_AVG:    w = '{MUL_NONE,  LD_AVG,    CND_NEVER,       STEP_IDLE};
         STEP_MUL_VOLT:  w = '{MUL_VOLT,  LD_NONE,   CND_NEVER,       STEP_IDLE};
         STEP_LD_VOLT:   w = '{MUL_NONE,  LD_VOLT,   CND_NEVER,       STEP_IDLE};
         STEP_MUL_QUAD:  w = '{MUL_QUAD,  LD_NONE,   CND_NEVER,       STEP_IDLE};
         STEP_LD_INNER:  w = '{MUL_NONE,  LD_INNER,  CND_NEVER,       STEP_IDLE};
         STEP_MUL_POLY:  w = '{MUL_POLY,  LD_NONE,   CND_NEVER,       STEP_IDLE};
         STEP_LD_RAW:    w = '{MUL_NONE,  LD_RAW,    CND_NEVER,       STEP_IDLE};
         STEP_MUL_DIV10: w = '{MUL_DIV10, LD_NONE,   CND_NEVER,       STEP_IDLE};
         STEP_RESULT:    w = '{MUL_NONE,  LD_RESULT, CND_OUT_BLOCKED, STEP_RESULT};
         STEP_RETURN:    w = '{MUL_NONE,  LD_NONE,   CND_ALWAYS,      STEP_IDLE};
         default:        w = '{MUL_NONE,  LD_NONE,   CND_ALWAYS,      STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* sv/turbidity_window_converter_unit.sv */
// Channel  Direction  Handshake            Transfer payload
// req      in         req_valid/req_stall  req_adc_sample
// rsp      out        rsp_valid/rsp_stall  average, voltage, turbidity, valid, status, echo
// csr      in/out     APB, pready high     four registers at byte addresses 0, 4, 8, 12
//
// One sample is taken per cycle while req_stall is low. When the last sample of a window
// is taken, its sum is captured and a 12-step microcode program runs the conversion on
// one shared 32x24 multiplier; rsp_valid rises when the program's result step loads the
// output register, later if rsp is stalled. The last sample of the next window waits until
// that program is back at its idle step. Reset is synchronous and active high; it restores
// the register reset values, empties the window and drops rsp_valid. A stalled result
// holds in the output register while the next window keeps filling.
module turbidity_window_converter_unit #(
   parameter int unsigned SAMPLES = twc_pkg::SAMPLES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample input.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [twc_pkg::SAMPLE_W-1:0]        req_adc_sample,
   // Result output.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [twc_pkg::SAMPLE_W-1:0]        rsp_average_count,
   output logic [twc_pkg::VOLT_W-1:0]          rsp_sensor_voltage,
   output logic [twc_pkg::TURB_W-1:0]          rsp_turbidity,
   output logic                                rsp_reading_valid,
   output logic [1:0]                          rsp_fault_status,
   output logic                                rsp_calibrated_echo,
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [twc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [twc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [twc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // The window counter only has to reach SAMPLES - 1, since it wraps to zero when
   // the window closes. The sum of a full window fits in SAMPLE_W + CNT_W bits.
   localparam int unsigned CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int unsigned SUM_W = twc_pkg::SAMPLE_W + CNT_W;

   // Reciprocal of the window length, rounded up, so that the high bits of the product
   // give the exact floor of the mean for every sum that a window can reach.
   localparam logic [twc_pkg::MUL_A_W-1:0] AVG_RECIP = twc_pkg::MUL_A_W'(
      ((64'd1 << twc_pkg::AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES - 1);

   localparam int unsigned PW = twc_pkg::PROD_W;

   // Registers and their next values.
   logic [twc_pkg::SCALE_W-1:0]  volt_scale_ff, volt_scale_in;
   logic                         cal_flag_ff, cal_flag_in;
   logic [twc_pkg::VOLT_W-1:0]   open_thr_ff, open_thr_in;
   logic [twc_pkg::TURB_W-1:0]   reject_lim_ff, reject_lim_in;

   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [SUM_W-1:0]             snap_ff, snap_in;
   logic                         go_ff, go_in;

   logic [twc_pkg::PC_W-1:0]     pc_ff, pc_in;
   logic [PW-1:0]                prod_ff, prod_in;
   logic [twc_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic [twc_pkg::VOLT_W-1:0]   volt_ff, volt_in;
   logic [31:0]                  inner_ff, inner_in;
   logic                         npos_ff, npos_in;
   logic [twc_pkg::Y_W-1:0]      y_ff, y_in;

   logic                         out_valid_ff, out_valid_in;
   logic [twc_pkg::SAMPLE_W-1:0] out_avg_ff, out_avg_in;
   logic [twc_pkg::VOLT_W-1:0]   out_volt_ff, out_volt_in;
   logic [twc_pkg::TURB_W-1:0]   out_turb_ff, out_turb_in;
   twc_pkg::fault_type           out_fault_ff, out_fault_in;
   logic                         out_cal_ff, out_cal_in;

   // Combinational helpers.
   twc_pkg::ctrl_word_type       ctrl;
   logic                         csr_write;
   logic [1:0]                   csr_index;
   logic                         req_take;
   logic                         last_sample;
   logic                         seq_busy;
   logic                         out_blocked;
   logic                         jump_taken;
   logic                         load_result;
   logic [twc_pkg::MUL_A_W-1:0]  mul_a;
   logic [twc_pkg::MUL_B_W-1:0]  mul_b;
   logic [23:0]                  volt_raw;
   logic [PW-1:0]                round_diff;
   logic [16:0]                  turb_raw;
   logic [twc_pkg::TURB_W-1:0]   turb_clamp;
   logic [twc_pkg::TURB_W-1:0]   turb_calc;
   logic [SUM_W-1:0]             sum_next;

   // The control word of the current step drives the whole datapath.
   assign ctrl = twc_pkg::program_rom(pc_ff);

   // ---------------------------------------------------------------------------
   // Register port. Writes land on the access phase; pready is tied high.
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      unique case (csr_index)
         twc_pkg::REG_VOLT_SCALE:   csr_prdata = twc_pkg::CSR_DATA_W'(volt_scale_ff);
         twc_pkg::REG_CALIBRATED:   csr_prdata = twc_pkg::CSR_DATA_W'(cal_flag_ff);
         twc_pkg::REG_OPEN_THRESH:  csr_prdata = twc_pkg::CSR_DATA_W'(open_thr_ff);
         twc_pkg::REG_REJECT_LIMIT: csr_prdata = twc_pkg::CSR_DATA_W'(reject_lim_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_comb begin
      volt_scale_in = volt_scale_ff;
      cal_flag_in   = cal_flag_ff;
      open_thr_in   = open_thr_ff;
      reject_lim_in = reject_lim_ff;
      if (csr_write) begin
         unique case (csr_index)
            twc_pkg::REG_VOLT_SCALE:   volt_scale_in = csr_pwdata[twc_pkg::SCALE_W-1:0];
            twc_pkg::REG_CALIBRATED:   cal_flag_in   = csr_pwdata[0];
            twc_pkg::REG_OPEN_THRESH:  open_thr_in   = csr_pwdata[twc_pkg::VOLT_W-1:0];
            twc_pkg::REG_REJECT_LIMIT: reject_lim_in = csr_pwdata[twc_pkg::TURB_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Window accumulation. Every sample is added as it arrives. The sample that
   // closes a window hands the finished sum to the sequencer through snap_ff, so
   // it has to wait while the sequencer still owns the previous snapshot.
   // ---------------------------------------------------------------------------
   assign seq_busy    = go_ff | (pc_ff != twc_pkg::STEP_IDLE);
   assign last_sample = (count_ff == LAST_COUNT);
   assign req_stall   = last_sample & seq_busy;
   assign req_take    = req_valid & ~req_stall;
   assign sum_next    = sum_ff + SUM_W'(req_adc_sample);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      snap_in  = snap_ff;
      go_in    = go_ff;
      // The sequencer claims the snapshot when it leaves its idle step.
      if (go_ff && (pc_ff == twc_pkg::STEP_IDLE)) begin
         go_in = 1'b0;
      end
      if (req_take) begin
         if (last_sample) begin
            snap_in  = sum_next;
            sum_in   = '0;
            count_in = '0;
            go_in    = 1'b1;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Step counter. A step either jumps to its target when its condition holds or
   // falls through to the next step. The result step spins on itself while the
   // output register still holds a result that has not been taken.
   // ---------------------------------------------------------------------------
   assign out_blocked = out_valid_ff & rsp_stall;

   always_comb begin
      unique case (ctrl.cond)
         twc_pkg::CND_NEVER:       jump_taken = 1'b0;
         twc_pkg::CND_ALWAYS:      jump_taken = 1'b1;
         twc_pkg::CND_NO_GO:       jump_taken = ~go_ff;
         twc_pkg::CND_OUT_BLOCKED: jump_taken = out_blocked;
         default:                  jump_taken = 1'b1;
      endcase
      pc_in = jump_taken ? ctrl.target : pc_ff + twc_pkg::PC_W'(1);
   end

   // ---------------------------------------------------------------------------
   // Shared multiplier. The operand pair is chosen by the control word and the
   // product is registered before any step uses it.
   // ---------------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.mul)
         twc_pkg::MUL_NONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         twc_pkg::MUL_AVG: begin
            mul_a = AVG_RECIP;
            mul_b = twc_pkg::MUL_B_W'(snap_ff);
         end
         twc_pkg::MUL_VOLT: begin
            mul_a = twc_pkg::MUL_A_W'(avg_ff);
            mul_b = volt_scale_ff;
         end
         twc_pkg::MUL_QUAD: begin
            mul_a = twc_pkg::MUL_A_W'(twc_pkg::COEF_SQ);
            mul_b = twc_pkg::MUL_B_W'(volt_ff[17:0]);
         end
         twc_pkg::MUL_POLY: begin
            mul_a = inner_ff;
            mul_b = twc_pkg::MUL_B_W'(volt_ff[17:0]);
         end
         twc_pkg::MUL_DIV10: begin
            mul_a = twc_pkg::MUL_A_W'(twc_pkg::RECIP_TEN);
            mul_b = twc_pkg::MUL_B_W'(y_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = (ctrl.mul == twc_pkg::MUL_NONE) ? prod_ff : (PW'(mul_a) * PW'(mul_b));
   end

   // ---------------------------------------------------------------------------
   // Load steps: each takes the registered product apart into the next working
   // value. Voltages of 2.5 V and more give zero turbidity, so only the low
   // 18 bits of the voltage enter the polynomial.
   // ---------------------------------------------------------------------------
   assign volt_raw   = prod_ff[35:12];
   assign round_diff = prod_ff + twc_pkg::ROUND_HALF - twc_pkg::POLY_OFFSET;
   assign turb_raw   = prod_ff[twc_pkg::TEN_SHIFT+16:twc_pkg::TEN_SHIFT];
   assign turb_clamp = (turb_raw > 17'(twc_pkg::NTU_MAX)) ? twc_pkg::NTU_MAX
                                                          : turb_raw[twc_pkg::TURB_W-1:0];
   assign turb_calc  = (!npos_ff || (volt_ff >= twc_pkg::V_CLEAR)) ? '0 : turb_clamp;
   assign load_result = (ctrl.load == twc_pkg::LD_RESULT) & ~out_blocked;

   always_comb begin
      avg_in   = avg_ff;
      volt_in  = volt_ff;
      inner_in = inner_ff;
      npos_in  = npos_ff;
      y_in     = y_ff;
      unique case (ctrl.load)
         twc_pkg::LD_AVG: begin
            avg_in = prod_ff[twc_pkg::AVG_SHIFT+11:twc_pkg::AVG_SHIFT];
         end
         twc_pkg::LD_VOLT: begin
            volt_in = (volt_raw > 24'(twc_pkg::VOLT_MAX)) ? twc_pkg::VOLT_MAX
                                                          : volt_raw[twc_pkg::VOLT_W-1:0];
         end
         twc_pkg::LD_INNER: begin
            inner_in = twc_pkg::COEF_LIN - prod_ff[31:0];
         end
         twc_pkg::LD_RAW: begin
            // N is positive exactly when the product exceeds the constant term.
            npos_in = (prod_ff > twc_pkg::POLY_OFFSET);
            y_in    = round_diff[twc_pkg::TURB_SHIFT+twc_pkg::Y_W-1:twc_pkg::TURB_SHIFT];
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Output register. It is loaded on the result step once the previous result
   // has gone, and rsp_valid drops after a transfer that is not replaced.
   // ---------------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      out_avg_in   = out_avg_ff;
      out_volt_in  = out_volt_ff;
      out_turb_in  = out_turb_ff;
      out_fault_in = out_fault_ff;
      out_cal_in   = out_cal_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (load_result) begin
         out_valid_in = 1'b1;
         out_avg_in   = avg_ff;
         out_volt_in  = volt_ff;
         out_cal_in   = cal_flag_ff;
         if (volt_ff < open_thr_ff) begin
            // An open probe reports no turbidity at all.
            out_turb_in  = '0;
            out_fault_in = twc_pkg::FAULT_OPEN;
         end else begin
            out_turb_in  = turb_calc;
            out_fault_in = (turb_calc > reject_lim_ff) ? twc_pkg::FAULT_REJECT
                                                       : twc_pkg::FAULT_OK;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_average_count   = out_avg_ff;
   assign rsp_sensor_voltage  = out_volt_ff;
   assign rsp_turbidity       = out_turb_ff;
   assign rsp_reading_valid   = (out_fault_ff == twc_pkg::FAULT_OK);
   assign rsp_fault_status    = out_fault_ff;
   assign rsp_calibrated_echo = out_cal_ff;

   // Control state and registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         volt_scale_ff <= twc_pkg::SCALE_RESET;
         cal_flag_ff   <= 1'b0;
         open_thr_ff   <= twc_pkg::OPEN_RESET;
         reject_lim_ff <= twc_pkg::REJECT_RESET;
         sum_ff        <= '0;
         count_ff      <= '0;
         go_ff         <= 1'b0;
         pc_ff         <= twc_pkg::STEP_IDLE;
         out_valid_ff  <= 1'b0;
      end else begin
         volt_scale_ff <= volt_scale_in;
         cal_flag_ff   <= cal_flag_in;
         open_thr_ff   <= open_thr_in;
         reject_lim_ff <= reject_lim_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         go_ff         <= go_in;
         pc_ff         <= pc_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Datapath and payload registers.
   always_ff @(posedge clock) begin
      snap_ff      <= snap_in;
      prod_ff      <= prod_in;
      avg_ff       <= avg_in;
      volt_ff      <= volt_in;
      inner_ff     <= inner_in;
      npos_ff      <= npos_in;
      y_ff         <= y_in;
      out_avg_ff   <= out_avg_in;
      out_volt_ff  <= out_volt_in;
      out_turb_ff  <= out_turb_in;
      out_fault_ff <= out_fault_in;
      out_cal_ff   <= out_cal_in;
   end

endmodule
